// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTC checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define RTC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define RTC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/rtc_pkg.sv =====
// ---------------------------------------------------------------------------
// rtc_pkg
// Types, codes, register offsets and ID bytes of the RTC block.
// ---------------------------------------------------------------------------
`default_nettype none

package rtc_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned OFF_W  = 12;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_WRONLY = 2'd1,
    ST_RDONLY = 2'd2,
    ST_BADOFF = 2'd3
  } status_t;

  localparam logic [OFF_W-1:0] OFF_DATA    = 12'h000;
  localparam logic [OFF_W-1:0] OFF_MATCH   = 12'h004;
  localparam logic [OFF_W-1:0] OFF_LOAD    = 12'h008;
  localparam logic [OFF_W-1:0] OFF_CTRL    = 12'h00C;
  localparam logic [OFF_W-1:0] OFF_MASK    = 12'h010;
  localparam logic [OFF_W-1:0] OFF_RAW     = 12'h014;
  localparam logic [OFF_W-1:0] OFF_MASKED  = 12'h018;
  localparam logic [OFF_W-1:0] OFF_CLEAR   = 12'h01C;

  // ID window 0xFE0..0xFFF: offset[11:5] all ones
  localparam logic [6:0] ID_WIN_HI = 7'h7F;

  typedef struct packed {
    logic [1:0]        operation;
    logic [OFF_W-1:0]  offset;
    logic [DATA_W-1:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              irq;
    logic [1:0]        access_status;
  } out_item_t;

  function automatic logic [7:0] id_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h31;
      3'd1:    b = 8'h10;
      3'd2:    b = 8'h14;
      3'd3:    b = 8'h00;
      3'd4:    b = 8'h0D;
      3'd5:    b = 8'hF0;
      3'd6:    b = 8'h05;
      3'd7:    b = 8'hB1;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rtc_if.sv =====
// ---------------------------------------------------------------------------
// rtc_in_if / rtc_out_if
// Valid/ready channels for RTC input items and result items.
// ---------------------------------------------------------------------------
`default_nettype none

interface rtc_in_if;
  import rtc_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [OFF_W-1:0]  offset;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, output operation, output offset, output write_data,
                  input ready);
  modport sink   (input valid, input operation, input offset, input write_data,
                  output ready);
endinterface

interface rtc_out_if;
  import rtc_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              irq;
  logic [1:0]        access_status;

  modport source (output valid, output read_data, output irq, output access_status,
                  input ready);
  modport sink   (input valid, input read_data, input irq, input access_status,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rtc_in_stage.sv =====
// ---------------------------------------------------------------------------
// rtc_in_stage
// Input register: captures one item per cycle when the core can take it.
// ---------------------------------------------------------------------------
`default_nettype none

module rtc_in_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  rtc_in_if.sink                 in_item,
  input  wire logic              advance,
  output rtc_pkg::in_item_t      item,
  output logic                   item_valid
);
  import rtc_pkg::*;

  logic     valid_r, valid_nxt;
  in_item_t item_r;
  logic     load;

  assign load          = !valid_r || advance;
  assign in_item.ready = load && rst_n;
  assign valid_nxt     = load ? in_item.valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_item.valid) begin
      item_r.operation  <= in_item.operation;
      item_r.offset     <= in_item.offset;
      item_r.write_data <= in_item.write_data;
    end
  end

  assign item       = item_r;
  assign item_valid = valid_r;

endmodule

`default_nettype wire

// ===== rtl/core/rtc_core.sv =====
// ---------------------------------------------------------------------------
// rtc_core
// Counter, match/load/mask/status registers, bus decode and alarm compare.
// ---------------------------------------------------------------------------
`default_nettype none

module rtc_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               fire,
  input  wire rtc_pkg::in_item_t  item,
  output rtc_pkg::out_item_t      result
);
  import rtc_pkg::*;

  logic [DATA_W-1:0] count_r, count_nxt;
  logic [DATA_W-1:0] match_r, match_nxt;
  logic [DATA_W-1:0] load_r,  load_nxt;
  logic              mask_r,  mask_nxt;
  logic              raw_r,   raw_nxt;
  logic [DATA_W-1:0] rd;
  status_t           st;

  always_comb begin
    count_nxt = count_r;
    match_nxt = match_r;
    load_nxt  = load_r;
    mask_nxt  = mask_r;
    raw_nxt   = raw_r;
    rd        = '0;
    st        = ST_OK;
    case (item.operation)
      OP_TICK: begin
        count_nxt = count_r + 32'd1;
        if (count_nxt == match_r) raw_nxt = 1'b1;
      end
      OP_READ: begin
        case (item.offset)
          OFF_DATA:   rd = count_r;
          OFF_MATCH:  rd = match_r;
          OFF_LOAD:   rd = load_r;
          OFF_CTRL:   rd = 32'd1;
          OFF_MASK:   rd = {31'd0, mask_r};
          OFF_RAW:    rd = {31'd0, raw_r};
          OFF_MASKED: rd = {31'd0, raw_r & mask_r};
          OFF_CLEAR:  st = ST_WRONLY;
          default: begin
            if (item.offset[11:5] == ID_WIN_HI) begin
              rd = {24'd0, id_byte(item.offset[4:2])};
            end else begin
              st = ST_BADOFF;
            end
          end
        endcase
      end
      OP_WRITE: begin
        case (item.offset)
          OFF_MATCH: begin
            match_nxt = item.write_data;
            if (count_r == item.write_data) raw_nxt = 1'b1;
          end
          OFF_LOAD: begin
            load_nxt  = item.write_data;
            count_nxt = item.write_data;
            if (item.write_data == match_r) raw_nxt = 1'b1;
          end
          OFF_CTRL:   st = ST_OK;
          OFF_MASK:   mask_nxt = item.write_data[0];
          OFF_CLEAR:  raw_nxt = raw_r & ~item.write_data[0];
          OFF_DATA:   st = ST_RDONLY;
          OFF_RAW:    st = ST_RDONLY;
          OFF_MASKED: st = ST_RDONLY;
          default:    st = ST_BADOFF;
        endcase
      end
      default: st = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      match_r <= '0;
      load_r  <= '0;
      mask_r  <= 1'b0;
      raw_r   <= 1'b0;
    end else if (fire) begin
      count_r <= count_nxt;
      match_r <= match_nxt;
      load_r  <= load_nxt;
      mask_r  <= mask_nxt;
      raw_r   <= raw_nxt;
    end
  end

  assign result.read_data     = rd;
  assign result.irq           = raw_nxt & mask_nxt;
  assign result.access_status = st;

endmodule

`default_nettype wire

// ===== rtl/core/rtc_out_stage.sv =====
// ---------------------------------------------------------------------------
// rtc_out_stage
// Result register: holds one result item until the receiver takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module rtc_out_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               fire,
  input  wire rtc_pkg::out_item_t result,
  output logic                    can_load,
  rtc_out_if.source               out_item
);
  import rtc_pkg::*;

  logic      valid_r, valid_nxt;
  out_item_t res_r;

  assign can_load  = !valid_r || out_item.ready;
  assign valid_nxt = can_load ? fire : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= result;
    end
  end

  assign out_item.valid         = valid_r;
  assign out_item.read_data     = res_r.read_data;
  assign out_item.irq           = res_r.irq;
  assign out_item.access_status = res_r.access_status;

endmodule

`default_nettype wire

// ===== rtl/core/rtc_seconds_counter_with_match_alarm.sv =====
// ---------------------------------------------------------------------------
// rtc_seconds_counter_with_match_alarm
// Register-mapped real-time clock with a 32-bit seconds counter and alarm.
// ---------------------------------------------------------------------------
// Usage:
//   in_item  : valid/ready channel; each item is a one-second tick, a bus
//              read or a bus write (operation, offset, write_data).
//   out_item : valid/ready channel; exactly one result item per input item
//              (read_data, irq level after the item, access_status).
//   Flow: an accepted item waits in the input register, is executed as it
//   moves into the result register, and its result is taken from there.
//   Throughput: one item per cycle while the receiver takes results; the
//   counter update, match compare and register decode are all combinational.
//   Reset (rst_n low, synchronous): counter, match, load, mask and status
//   clear to zero; both channels go empty.
//   When the receiver stalls, the result register holds its item and the
//   input register fills; in_item.ready then drops until out_item.ready
//   returns, so nothing is lost or repeated.
// ---------------------------------------------------------------------------
`default_nettype none

module rtc_seconds_counter_with_match_alarm (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rtc_in_if.sink     in_item,
  rtc_out_if.source  out_item
);
  import rtc_pkg::*;

  in_item_t  item;
  logic      item_valid;
  logic      can_load;
  logic      fire;
  out_item_t result;

  assign fire = item_valid && can_load;

  rtc_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .advance    (can_load),
    .item       (item),
    .item_valid (item_valid)
  );

  rtc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (item),
    .result (result)
  );

  rtc_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .result   (result),
    .can_load (can_load),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

// ===== rtl/core/rtc_checker.sv =====
// ---------------------------------------------------------------------------
// rtc_checker
// Port-level assertions on the RTC result channel, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rtc_checker (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        out_valid,
  input  wire logic                        out_ready,
  input  wire logic [rtc_pkg::DATA_W-1:0]  out_read_data,
  input  wire logic                        out_irq,
  input  wire logic [1:0]                  out_access_status
);
  import rtc_pkg::*;

  `RTC_ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> !out_valid, "result valid after reset")
  `RTC_ASSERT(a_valid_holds, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped")
  `RTC_ASSERT(a_payload_holds, clk, rst_n, out_valid && !out_ready |=> $stable(out_read_data) && $stable(out_irq) && $stable(out_access_status), "stalled result changed")
  `RTC_ASSERT(a_data_only_ok, clk, rst_n, out_valid && out_access_status != ST_OK |-> out_read_data == '0, "read data with error status")

endmodule

bind rtc_seconds_counter_with_match_alarm rtc_checker u_rtc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_item.valid),
  .out_ready         (out_item.ready),
  .out_read_data     (out_item.read_data),
  .out_irq           (out_item.irq),
  .out_access_status (out_item.access_status)
);

`default_nettype wire
